@@ rtl/vgpa_pkg.sv @@
// ---------------------------------------------------------------------------
// vgpa_pkg
// Shared types and constants of the padding-aware volume gradient block.
// ---------------------------------------------------------------------------
package vgpa_pkg;

  localparam int VAL_W  = 16;  // voxel sample
  localparam int INV_W  = 24;  // reciprocal spacing, unsigned Q8.16
  localparam int RES_W  = 48;  // result fields
  localparam int CFG_W  = 24;  // widest register
  localparam int DIFF_W = 17;  // difference of two samples
  localparam int PROD_W = 41;  // difference times reciprocal spacing
  localparam int ABS_W  = 40;  // magnitude of one gradient component
  localparam int HALF_W = 20;  // partial product operand
  localparam int SUM_W  = 82;  // sum of three squares
  localparam int ROOT_W = 41;  // floor square root of the sum
  localparam int REM_W  = 44;  // square root remainder

  typedef enum logic [2:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_DEPTH   = 3'd2,
    REG_PADDING = 3'd3,
    REG_INV_X   = 3'd4,
    REG_INV_Y   = 3'd5,
    REG_INV_Z   = 3'd6,
    REG_MODE    = 3'd7
  } reg_idx_t;

  localparam logic [2:0] MODE_X   = 3'd0;
  localparam logic [2:0] MODE_Y   = 3'd1;
  localparam logic [2:0] MODE_Z   = 3'd2;
  localparam logic [2:0] MODE_MAG = 3'd3;
  localparam logic [2:0] MODE_VEC = 3'd4;

  localparam logic OP_VOXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Classification of one queued job
  typedef struct packed {
    logic emit;   // a result is due
    logic wr;     // the voxel is stored
    logic xl;
    logic xh;
    logic yl;
    logic yh;
    logic zl;
    logic zh;     // upper z neighbour is the incoming voxel
    logic last;
    logic epar;   // slice parity of the result voxel
    logic wpar;   // slice parity of the stored voxel
  } job_ctl_t;

endpackage

@@ rtl/vgpa_queue.sv @@
// ---------------------------------------------------------------------------
// vgpa_queue
// Short job queue between the classifying front and the compute back end.
// ---------------------------------------------------------------------------
module vgpa_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              nonempty,
  output logic [DATA_W-1:0] head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] q_mem [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [NW-1:0]     count_r;
  logic              do_push;
  logic              do_pop;

  assign full     = count_r == NW'(DEPTH);
  assign nonempty = count_r != '0;
  assign head     = q_mem[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + NW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(DEPTH))
    else $error("queue count past depth");
  a_pop_drops: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop && !do_push |=> count_r == $past(count_r) - NW'(1))
    else $error("queue count not reduced on pop");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> count_r == $past(count_r) + NW'(1))
    else $error("queue count not raised on push");

endmodule

@@ rtl/vgpa_front.sv @@
// ---------------------------------------------------------------------------
// vgpa_front
// Accepts voxel and drain transactions and keeps the raster counters. Turns
// voxels (volume open) and drains (volume complete) into store/compute jobs.
// ---------------------------------------------------------------------------
module vgpa_front
  import vgpa_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_DEPTH  = 1024,
  parameter int XW         = 8,
  parameter int YW         = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              in_opcode,
  input  logic [VAL_W-1:0]  in_voxel_value,
  output logic              in_full,
  input  logic [8:0]        width_count,
  input  logic [8:0]        height_count,
  input  logic [10:0]       depth_count,
  input  logic              q_full,
  output logic              q_push,
  output job_ctl_t          job_ctl,
  output logic [XW-1:0]     job_x,
  output logic [YW-1:0]     job_y,
  output logic [VAL_W-1:0]  job_value
);

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int ZW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int ZCW = $clog2(MAX_DEPTH + 1);
  localparam int PW  = ZCW + YW + XW;

  logic [XW-1:0]  in_col_r, out_col_r, ex;
  logic [YW-1:0]  in_row_r, out_row_r, ey;
  logic [ZW-1:0]  in_slice_r, out_slice_r, ez;
  logic           complete_r;
  logic [CW-1:0]  w_eff;
  logic [RW-1:0]  h_eff;
  logic [ZCW-1:0] d_eff;
  logic           is_voxel;
  logic           accept;
  logic           emit;
  logic           last;
  logic [PW-1:0]  adv_in;
  logic [PW-1:0]  adv_em;
  logic [ZCW-1:0] adv_in_s, adv_em_s;

  function automatic logic [PW-1:0] advance_pos(input logic [XW-1:0] c,
                                                input logic [YW-1:0] r,
                                                input logic [ZW-1:0] s,
                                                input logic [CW-1:0] w,
                                                input logic [RW-1:0] h);
    logic [CW-1:0]  c1;
    logic [RW-1:0]  r1;
    logic [ZCW-1:0] s1;
    c1 = CW'(c) + CW'(1);
    r1 = RW'(r);
    s1 = ZCW'(s);
    if (c1 >= w) begin
      c1 = '0;
      r1 = RW'(r) + RW'(1);
      if (r1 >= h) begin
        r1 = '0;
        s1 = ZCW'(s) + ZCW'(1);
      end
    end
    return {s1, r1[YW-1:0], c1[XW-1:0]};
  endfunction

  // Dimensions clamped to 1..MAX
  always_comb begin
    if (width_count == '0) begin
      w_eff = CW'(1);
    end else if (32'(width_count) > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_count);
    end
    if (height_count == '0) begin
      h_eff = RW'(1);
    end else if (32'(height_count) > 32'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(height_count);
    end
    if (depth_count == '0) begin
      d_eff = ZCW'(1);
    end else if (32'(depth_count) > 32'(MAX_DEPTH)) begin
      d_eff = ZCW'(MAX_DEPTH);
    end else begin
      d_eff = ZCW'(depth_count);
    end
  end

  always_comb begin
    is_voxel = in_opcode == OP_VOXEL;
    accept   = in_push && !q_full;
    if (is_voxel) begin
      ex   = in_col_r;
      ey   = in_row_r;
      ez   = in_slice_r - ZW'(1);
      emit = !complete_r && (in_slice_r != '0);
    end else begin
      ex   = out_col_r;
      ey   = out_row_r;
      ez   = out_slice_r;
      emit = complete_r;
    end
    last = (CW'(ex) + CW'(1) >= w_eff) && (RW'(ey) + RW'(1) >= h_eff) &&
           (ZCW'(ez) + ZCW'(1) >= d_eff);
    adv_in   = advance_pos(in_col_r, in_row_r, in_slice_r, w_eff, h_eff);
    adv_em   = advance_pos(ex, ey, ez, w_eff, h_eff);
    adv_in_s = adv_in[PW-1 -: ZCW];
    adv_em_s = adv_em[PW-1 -: ZCW];

    job_ctl.emit = emit;
    job_ctl.wr   = is_voxel;
    job_ctl.xl   = ex != '0;
    job_ctl.xh   = CW'(ex) + CW'(1) < w_eff;
    job_ctl.yl   = ey != '0;
    job_ctl.yh   = RW'(ey) + RW'(1) < h_eff;
    job_ctl.zl   = ez != '0;
    job_ctl.zh   = is_voxel;
    job_ctl.last = last;
    job_ctl.epar = ez[0];
    job_ctl.wpar = in_slice_r[0];
  end

  assign job_x     = ex;
  assign job_y     = ey;
  assign job_value = in_voxel_value;
  assign in_full   = q_full;
  assign q_push    = accept && (is_voxel ? !complete_r : complete_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_slice_r  <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_slice_r <= '0;
      complete_r  <= 1'b0;
    end else if (q_push) begin
      if (emit && (!is_voxel && (last || adv_em_s >= d_eff))) begin
        out_col_r   <= '0;
        out_row_r   <= '0;
        out_slice_r <= '0;
        complete_r  <= 1'b0;
      end else if (emit) begin
        out_col_r   <= adv_em[XW-1:0];
        out_row_r   <= adv_em[XW +: YW];
        out_slice_r <= adv_em_s[ZW-1:0];
      end
      if (is_voxel) begin
        if (adv_in_s >= d_eff) begin
          in_col_r   <= '0;
          in_row_r   <= '0;
          in_slice_r <= '0;
          complete_r <= 1'b1;
        end else begin
          in_col_r   <= adv_in[XW-1:0];
          in_row_r   <= adv_in[XW +: YW];
          in_slice_r <= adv_in_s[ZW-1:0];
        end
      end
    end
  end

  a_drain_needs_volume: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !is_voxel |-> complete_r)
    else $error("drain job queued while volume still arriving");
  a_voxel_open: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && is_voxel |-> !complete_r)
    else $error("voxel job queued after volume complete");
  a_first_slice_silent: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && is_voxel && in_slice_r == '0 |-> !job_ctl.emit)
    else $error("result due on first slice");

endmodule

@@ rtl/vgpa_back.sv @@
// ---------------------------------------------------------------------------
// vgpa_back
// Holds the two-slice store; for each result job reads the neighbours,
// forms the gradients (plus magnitude in MAG mode), presents the result.
// ---------------------------------------------------------------------------
module vgpa_back
  import vgpa_pkg::*;
#(
  parameter int XW = 8,
  parameter int YW = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    job_valid,
  input  job_ctl_t                job_ctl,
  input  logic [XW-1:0]           job_x,
  input  logic [YW-1:0]           job_y,
  input  logic [VAL_W-1:0]        job_value,
  output logic                    job_pop,
  input  logic signed [VAL_W-1:0] padding_level,
  input  logic [INV_W-1:0]        inv_spacing_x,
  input  logic [INV_W-1:0]        inv_spacing_y,
  input  logic [INV_W-1:0]        inv_spacing_z,
  input  logic [2:0]              output_mode,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic signed [RES_W-1:0] out_first_value,
  output logic signed [RES_W-1:0] out_second_value,
  output logic signed [RES_W-1:0] out_third_value,
  output logic                    out_last_voxel
);

  localparam int AW = 1 + YW + XW;
  localparam logic [2:0] LAST_STEP = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_GRAD, S_SQR, S_SQRT, S_OUT
  } state_t;

  state_t                   state_r;
  job_ctl_t                 ctl_r;
  logic [XW-1:0]            x_r;
  logic [YW-1:0]            y_r;
  logic signed [VAL_W-1:0]  val_r;
  logic [2:0]               step_r;
  logic signed [VAL_W-1:0]  nb_r [6];   // centre, x-, x+, y-, y+, z-
  logic [1:0]               axis_r;
  logic [1:0]               part_r;
  logic signed [PROD_W-1:0] gx_r, gy_r, gz_r;
  logic [SUM_W-1:0]         sum_r;
  logic [SUM_W-1:0]         rad_r;
  logic [REM_W-1:0]         rem_r;
  logic [ROOT_W-1:0]        root_r;
  logic [5:0]               cnt_r;
  logic                     out_valid_r;
  logic signed [RES_W-1:0]  first_r, second_r, third_r;
  logic                     last_r;

  logic [VAL_W-1:0]         store_mem [2**AW];
  logic [VAL_W-1:0]         rdata_r;
  logic                     mem_we;
  logic [AW-1:0]            mem_wa, mem_ra;
  logic [VAL_W-1:0]         mem_wd;

  logic signed [VAL_W-1:0]  c_v, lo_raw, hi_raw, lo_v, hi_v;
  logic                     dl, dh, ql, qh;
  logic [INV_W-1:0]         inv_sel;
  logic signed [DIFF_W-1:0] diff;
  logic                     half;
  logic signed [PROD_W:0]   prod;
  logic signed [PROD_W-1:0] grad;
  logic signed [PROD_W-1:0] g_sel;
  logic [PROD_W-1:0]        g_abs;
  logic [HALF_W-1:0]        op_a, op_b;
  logic [2*HALF_W-1:0]      sq_prod;
  logic [SUM_W-1:0]         sum_nxt;
  logic [REM_W-1:0]         rem_sh, trial;
  logic                     out_load;

  // ---- store ----
  always_comb begin
    mem_we = 1'b0;
    mem_wa = {ctl_r.wpar, y_r, x_r};
    mem_wd = val_r;
    if (state_r == S_IDLE && job_valid && !job_ctl.emit && job_ctl.wr) begin
      mem_we = 1'b1;
      mem_wa = {job_ctl.wpar, job_y, job_x};
      mem_wd = job_value;
    end else if (state_r == S_READ && step_r == LAST_STEP && ctl_r.wr) begin
      mem_we = 1'b1;
    end
    unique case (step_r)
      3'd1:    mem_ra = {ctl_r.epar, y_r, x_r - XW'(1)};
      3'd2:    mem_ra = {ctl_r.epar, y_r, x_r + XW'(1)};
      3'd3:    mem_ra = {ctl_r.epar, y_r - YW'(1), x_r};
      3'd4:    mem_ra = {ctl_r.epar, y_r + YW'(1), x_r};
      3'd5:    mem_ra = {~ctl_r.epar, y_r, x_r};
      default: mem_ra = {ctl_r.epar, y_r, x_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_wa] <= mem_wd;
    end
    rdata_r <= store_mem[mem_ra];
  end

  assign job_pop = state_r == S_IDLE && job_valid;

  // ---- one axis per cycle ----
  always_comb begin
    c_v = nb_r[0];
    unique case (axis_r)
      2'd0: begin
        lo_raw = nb_r[1]; hi_raw = nb_r[2]; dl = ctl_r.xl; dh = ctl_r.xh;
        inv_sel = inv_spacing_x;
      end
      2'd1: begin
        lo_raw = nb_r[3]; hi_raw = nb_r[4]; dl = ctl_r.yl; dh = ctl_r.yh;
        inv_sel = inv_spacing_y;
      end
      default: begin
        lo_raw = nb_r[5]; hi_raw = val_r; dl = ctl_r.zl; dh = ctl_r.zh;
        inv_sel = inv_spacing_z;
      end
    endcase
    lo_v = dl ? lo_raw : c_v;
    hi_v = dh ? hi_raw : c_v;
    ql   = lo_v > padding_level;
    qh   = hi_v > padding_level;
    diff = '0;
    half = 1'b0;
    if (c_v > padding_level && (dl || dh)) begin
      priority if (qh && ql) begin
        diff = DIFF_W'(hi_v) - DIFF_W'(lo_v);
        half = dl && dh;
      end else if (qh && dh) begin
        diff = DIFF_W'(hi_v) - DIFF_W'(c_v);
      end else if (ql && dl) begin
        diff = DIFF_W'(c_v) - DIFF_W'(lo_v);
      end else begin
        diff = '0;
      end
    end
    prod = diff * $signed({1'b0, inv_sel});
    grad = half ? PROD_W'(prod >>> 1) : PROD_W'(prod);
  end

  // ---- squares as 20x20 partial products ----
  always_comb begin
    unique case (axis_r)
      2'd0:    g_sel = gx_r;
      2'd1:    g_sel = gy_r;
      default: g_sel = gz_r;
    endcase
    g_abs = g_sel[PROD_W-1] ? PROD_W'(-g_sel) : PROD_W'(g_sel);
    unique case (part_r)
      2'd0: begin op_a = g_abs[HALF_W-1:0];        op_b = g_abs[HALF_W-1:0]; end
      2'd1: begin op_a = g_abs[ABS_W-1:HALF_W];    op_b = g_abs[HALF_W-1:0]; end
      default: begin op_a = g_abs[ABS_W-1:HALF_W]; op_b = g_abs[ABS_W-1:HALF_W]; end
    endcase
    sq_prod = op_a * op_b;
    unique case (part_r)
      2'd0:    sum_nxt = sum_r + SUM_W'(sq_prod);
      2'd1:    sum_nxt = sum_r + (SUM_W'(sq_prod) << (HALF_W + 1));
      default: sum_nxt = sum_r + (SUM_W'(sq_prod) << (2 * HALF_W));
    endcase
  end

  // ---- square root, one result bit per cycle ----
  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], rad_r[SUM_W-1 -: 2]};
    trial  = REM_W'({root_r, 2'b01});
  end

  assign out_load  = state_r == S_OUT && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      axis_r      <= '0;
      part_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (job_valid && job_ctl.emit) begin
            ctl_r   <= job_ctl;
            x_r     <= job_x;
            y_r     <= job_y;
            val_r   <= job_value;
            step_r  <= '0;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          if (step_r != '0) begin
            nb_r[5] <= rdata_r;
            for (int i = 0; i < 5; i++) begin
              nb_r[i] <= nb_r[i+1];
            end
          end
          if (step_r == LAST_STEP) begin
            axis_r  <= '0;
            state_r <= S_GRAD;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        S_GRAD: begin
          unique case (axis_r)
            2'd0:    gx_r <= grad;
            2'd1:    gy_r <= grad;
            default: gz_r <= grad;
          endcase
          if (axis_r == 2'd2) begin
            axis_r <= '0;
            part_r <= '0;
            sum_r  <= '0;
            state_r <= (output_mode == MODE_MAG) ? S_SQR : S_OUT;
          end else begin
            axis_r <= axis_r + 2'd1;
          end
        end
        S_SQR: begin
          sum_r <= sum_nxt;
          if (part_r == 2'd2) begin
            part_r <= '0;
            if (axis_r == 2'd2) begin
              rad_r   <= sum_nxt;
              rem_r   <= '0;
              root_r  <= '0;
              cnt_r   <= 6'(ROOT_W - 1);
              state_r <= S_SQRT;
            end else begin
              axis_r <= axis_r + 2'd1;
            end
          end else begin
            part_r <= part_r + 2'd1;
          end
        end
        S_SQRT: begin
          rad_r <= rad_r << 2;
          if (rem_sh >= trial) begin
            rem_r  <= rem_sh - trial;
            root_r <= {root_r[ROOT_W-2:0], 1'b1};
          end else begin
            rem_r  <= rem_sh;
            root_r <= {root_r[ROOT_W-2:0], 1'b0};
          end
          if (cnt_r == '0) begin
            state_r <= S_OUT;
          end else begin
            cnt_r <= cnt_r - 6'd1;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      last_r <= ctl_r.last;
      unique case (output_mode)
        MODE_X: begin
          first_r  <= RES_W'(gx_r);
          second_r <= '0;
          third_r  <= '0;
        end
        MODE_Y: begin
          first_r  <= RES_W'(gy_r);
          second_r <= '0;
          third_r  <= '0;
        end
        MODE_Z: begin
          first_r  <= RES_W'(gz_r);
          second_r <= '0;
          third_r  <= '0;
        end
        MODE_MAG: begin
          first_r  <= RES_W'({1'b0, root_r});
          second_r <= '0;
          third_r  <= '0;
        end
        MODE_VEC: begin
          first_r  <= RES_W'(gx_r);
          second_r <= RES_W'(gy_r);
          third_r  <= RES_W'(gz_r);
        end
        default: begin
          first_r  <= '0;
          second_r <= '0;
          third_r  <= '0;
        end
      endcase
    end
  end

  assign out_first_value  = first_r;
  assign out_second_value = second_r;
  assign out_third_value  = third_r;
  assign out_last_voxel   = last_r;

  a_pop_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> state_r == S_IDLE)
    else $error("job taken while busy");
  a_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == S_IDLE || (state_r == S_READ && step_r == LAST_STEP))
    else $error("store written outside its window");
  a_read_to_grad: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ && step_r == LAST_STEP |=> state_r == S_GRAD && axis_r == 2'd0)
    else $error("neighbour fetch did not hand over");
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_valid_r && !out_pop |=> state_r == S_OUT)
    else $error("result overwritten before it was taken");

endmodule

@@ rtl/volume_gradient_padding_aware_core.sv @@
// ---------------------------------------------------------------------------
// volume_gradient_padding_aware_core
// Padding-aware 3D central difference gradient over a raster voxel stream.
// ---------------------------------------------------------------------------
// Voxels enter in raster order (column, row, slice); the result for a voxel
// leaves when the voxel one slice further on arrives, and drain transactions
// flush the final slice. A job queue decouples intake from compute: intake
// takes one transaction per cycle while the queue has room. The back end
// reads the centre sample and its five neighbours through the single read
// port of the two-slice store, one per cycle, then forms the x, y and z
// components; magnitude mode adds 20x20 partial products and a bit-serial
// square root. A transaction without a result (first slice) only stores
// its voxel. The store is not cleared and holds 2 x 2^ceil(log2 MAX_HEIGHT)
// x 2^ceil(log2 MAX_WIDTH) samples; a sample read from an entry that was
// not yet written is never used.
module volume_gradient_padding_aware_core
  import vgpa_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_DEPTH  = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic                    in_opcode,
  input  logic signed [VAL_W-1:0] in_voxel_value,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic signed [RES_W-1:0] out_first_value,
  output logic signed [RES_W-1:0] out_second_value,
  output logic signed [RES_W-1:0] out_third_value,
  output logic                    out_last_voxel,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CTL_W  = $bits(job_ctl_t);
  localparam int JOB_W  = CTL_W + XW + YW + VAL_W;

  logic [8:0]              width_count_r;
  logic [8:0]              height_count_r;
  logic [10:0]             depth_count_r;
  logic signed [VAL_W-1:0] padding_level_r;
  logic [INV_W-1:0]        inv_x_r, inv_y_r, inv_z_r;
  logic [2:0]              mode_r;

  job_ctl_t                f_ctl, b_ctl;
  logic [XW-1:0]           f_x, b_x;
  logic [YW-1:0]           f_y, b_y;
  logic [VAL_W-1:0]        f_val, b_val;
  logic                    q_push, q_full, q_pop, q_nonempty;
  logic [JOB_W-1:0]        q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_count_r   <= 9'd256;
      height_count_r  <= 9'd256;
      depth_count_r   <= 11'd1;
      padding_level_r <= 16'sh8000;
      inv_x_r         <= 24'd65536;
      inv_y_r         <= 24'd65536;
      inv_z_r         <= 24'd65536;
      mode_r          <= MODE_MAG;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WIDTH:   width_count_r   <= cfg_wdata[8:0];
        REG_HEIGHT:  height_count_r  <= cfg_wdata[8:0];
        REG_DEPTH:   depth_count_r   <= cfg_wdata[10:0];
        REG_PADDING: padding_level_r <= cfg_wdata[VAL_W-1:0];
        REG_INV_X:   inv_x_r         <= cfg_wdata;
        REG_INV_Y:   inv_y_r         <= cfg_wdata;
        REG_INV_Z:   inv_z_r         <= cfg_wdata;
        REG_MODE:    mode_r          <= cfg_wdata[2:0];
        default:     mode_r          <= mode_r;
      endcase
    end
  end

  vgpa_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_DEPTH  (MAX_DEPTH),
    .XW         (XW),
    .YW         (YW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_opcode      (in_opcode),
    .in_voxel_value (in_voxel_value),
    .in_full        (in_full),
    .width_count    (width_count_r),
    .height_count   (height_count_r),
    .depth_count    (depth_count_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .job_ctl        (f_ctl),
    .job_x          (f_x),
    .job_y          (f_y),
    .job_value      (f_val)
  );

  vgpa_queue #(
    .DATA_W (JOB_W),
    .DEPTH  (4)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_ctl, f_x, f_y, f_val}),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  assign b_ctl = q_head[JOB_W-1 -: CTL_W];
  assign b_x   = q_head[VAL_W + YW +: XW];
  assign b_y   = q_head[VAL_W +: YW];
  assign b_val = q_head[VAL_W-1:0];

  vgpa_back #(
    .XW (XW),
    .YW (YW)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .job_valid        (q_nonempty),
    .job_ctl          (b_ctl),
    .job_x            (b_x),
    .job_y            (b_y),
    .job_value        (b_val),
    .job_pop          (q_pop),
    .padding_level    (padding_level_r),
    .inv_spacing_x    (inv_x_r),
    .inv_spacing_y    (inv_y_r),
    .inv_spacing_z    (inv_z_r),
    .output_mode      (mode_r),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_first_value  (out_first_value),
    .out_second_value (out_second_value),
    .out_third_value  (out_third_value),
    .out_last_voxel   (out_last_voxel)
  );

endmodule
